// ===== design/sdftd_pkg.sv =====
`default_nettype none

package sdftd_pkg;

    // header capture
    localparam int unsigned HDR_LEN   = 12;
    localparam int unsigned HDR_IDX_W = 4;

    typedef logic [0:HDR_LEN-1][7:0] t_hdr;
    typedef logic [HDR_IDX_W-1:0]    t_hdr_len;

    // input and result items
    typedef struct packed {
        logic [7:0] cipher_byte;
        logic       is_last;
    } t_in;

    typedef struct packed {
        logic [7:0] plain_byte;
        logic       last_out;
        logic [4:0] type_code;
    } t_out;

    // type codes
    localparam logic [4:0] TC_NONE = 5'd0;
    localparam logic [4:0] TC_3GP  = 5'd1;
    localparam logic [4:0] TC_AVI  = 5'd2;
    localparam logic [4:0] TC_BMP  = 5'd3;
    localparam logic [4:0] TC_JPG  = 5'd4;
    localparam logic [4:0] TC_EXE  = 5'd5;
    localparam logic [4:0] TC_XLS  = 5'd6;
    localparam logic [4:0] TC_DOC  = 5'd7;
    localparam logic [4:0] TC_PPT  = 5'd8;
    localparam logic [4:0] TC_DOCX = 5'd9;
    localparam logic [4:0] TC_XLSX = 5'd10;
    localparam logic [4:0] TC_PPTX = 5'd11;
    localparam logic [4:0] TC_PDF  = 5'd12;
    localparam logic [4:0] TC_MP3  = 5'd13;
    localparam logic [4:0] TC_MP4  = 5'd14;
    localparam logic [4:0] TC_PNG  = 5'd15;
    localparam logic [4:0] TC_GZ   = 5'd16;

    // found flag bits
    localparam int unsigned FL_WORD = 0;
    localparam int unsigned FL_XL   = 1;
    localparam int unsigned FL_PPT  = 2;

    // path strings, newest byte lowest
    localparam logic [39:0] STR_WORD = 40'h776F72642F;
    localparam logic [23:0] STR_XL   = 24'h786C2F;
    localparam logic [31:0] STR_PPT  = 32'h7070742F;

    // magic numbers, byte 0 first, unused bytes zero
    localparam t_hdr MG_3GP  = {8'h00, 8'h00, 8'h00, 8'h14, 8'h66, 8'h74,
                                8'h79, 8'h70, 8'h33, 8'h67, 8'h70, 8'h34};
    localparam t_hdr MG_AVI  = {8'h52, 8'h49, 8'h46, 8'h46, 64'h0};
    localparam t_hdr MG_BMP  = {8'h42, 8'h4D, 80'h0};
    localparam t_hdr MG_JPG  = {8'hFF, 8'hD8, 8'hFF, 8'hE0, 64'h0};
    localparam t_hdr MG_EXE  = {8'h4D, 8'h5A, 80'h0};
    localparam t_hdr MG_OLE  = {8'hD0, 8'hCF, 8'h11, 8'hE0, 8'hA1, 8'hB1,
                                8'h1A, 8'hE1, 32'h0};
    localparam t_hdr MG_ZIP  = {8'h50, 8'h4B, 8'h03, 8'h04, 64'h0};
    localparam t_hdr MG_PDF  = {8'h25, 8'h50, 8'h44, 8'h46, 8'h2D, 56'h0};
    localparam t_hdr MG_MP3A = {8'hFF, 8'hFB, 80'h0};
    localparam t_hdr MG_MP3B = {8'hFF, 8'hF3, 80'h0};
    localparam t_hdr MG_MP3C = {8'h49, 8'h44, 8'h33, 72'h0};
    localparam t_hdr MG_MP4A = {8'h00, 8'h00, 8'h00, 8'h18, 8'h66, 8'h74,
                                8'h79, 8'h70, 8'h6D, 8'h70, 8'h34, 8'h32};
    localparam t_hdr MG_MP4B = {8'h00, 8'h00, 8'h00, 8'h14, 8'h66, 8'h74,
                                8'h79, 8'h70, 8'h69, 8'h73, 8'h6F, 8'h6D};
    localparam t_hdr MG_PNG  = {8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A,
                                8'h1A, 8'h0A, 32'h0};
    localparam t_hdr MG_GZ   = {8'h1F, 8'h8B, 8'h08, 72'h0};

    // OLE subtype bytes, placed at their absolute positions
    localparam t_hdr TL_XLS  = {64'h0, 8'h09, 8'h08, 16'h0};
    localparam t_hdr TL_DOC  = {64'h0, 8'h00, 8'h46, 8'h49, 8'h4C};
    localparam t_hdr TL_PPT  = {64'h0, 8'h00, 8'h6E, 8'h1E, 8'hF0};

    // True when the file holds bytes pos..pos+n-1 and they equal want there
    function automatic logic hdr_match(input t_hdr hdr, input t_hdr_len len,
                                       input t_hdr_len pos, input t_hdr want,
                                       input t_hdr_len n);
        logic [HDR_IDX_W:0] stop;
        logic               ok;
        stop = {1'b0, pos} + {1'b0, n};
        ok   = ({1'b0, len} >= stop);
        for (int i = 0; i < HDR_LEN; i++) begin
            if ((HDR_IDX_W+1)'(i) >= {1'b0, pos} && (HDR_IDX_W+1)'(i) < stop &&
                hdr[i] != want[i]) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

// ===== design/sdftd_classify.sv =====
`default_nettype none

module sdftd_classify (
    input  wire sdftd_pkg::t_hdr     i_hdr,
    input  wire sdftd_pkg::t_hdr_len i_len,
    input  wire [2:0]                i_found,
    output logic [4:0]               o_type_code
);

    logic is_ole;
    logic is_zip;

    // shared prefixes of the container formats
    assign is_ole = sdftd_pkg::hdr_match(i_hdr, i_len, 4'd0, sdftd_pkg::MG_OLE, 4'd8);
    assign is_zip = sdftd_pkg::hdr_match(i_hdr, i_len, 4'd0, sdftd_pkg::MG_ZIP, 4'd4);

    // walk the table in order, first hit wins
    always_comb begin
        priority if (sdftd_pkg::hdr_match(i_hdr, i_len, 4'd0, sdftd_pkg::MG_3GP, 4'd12)) begin
            o_type_code = sdftd_pkg::TC_3GP;
        end else if (sdftd_pkg::hdr_match(i_hdr, i_len, 4'd0, sdftd_pkg::MG_AVI, 4'd4)) begin
            o_type_code = sdftd_pkg::TC_AVI;
        end else if (sdftd_pkg::hdr_match(i_hdr, i_len, 4'd0, sdftd_pkg::MG_BMP, 4'd2)) begin
            o_type_code = sdftd_pkg::TC_BMP;
        end else if (sdftd_pkg::hdr_match(i_hdr, i_len, 4'd0, sdftd_pkg::MG_JPG, 4'd4)) begin
            o_type_code = sdftd_pkg::TC_JPG;
        end else if (sdftd_pkg::hdr_match(i_hdr, i_len, 4'd0, sdftd_pkg::MG_EXE, 4'd2)) begin
            o_type_code = sdftd_pkg::TC_EXE;
        end else if (is_ole &&
                     sdftd_pkg::hdr_match(i_hdr, i_len, 4'd8, sdftd_pkg::TL_XLS, 4'd2)) begin
            o_type_code = sdftd_pkg::TC_XLS;
        end else if (is_ole &&
                     sdftd_pkg::hdr_match(i_hdr, i_len, 4'd8, sdftd_pkg::TL_DOC, 4'd4)) begin
            o_type_code = sdftd_pkg::TC_DOC;
        end else if (is_ole &&
                     sdftd_pkg::hdr_match(i_hdr, i_len, 4'd8, sdftd_pkg::TL_PPT, 4'd4)) begin
            o_type_code = sdftd_pkg::TC_PPT;
        end else if (is_zip && i_found[sdftd_pkg::FL_WORD]) begin
            o_type_code = sdftd_pkg::TC_DOCX;
        end else if (is_zip && i_found[sdftd_pkg::FL_XL]) begin
            o_type_code = sdftd_pkg::TC_XLSX;
        end else if (is_zip && i_found[sdftd_pkg::FL_PPT]) begin
            o_type_code = sdftd_pkg::TC_PPTX;
        end else if (sdftd_pkg::hdr_match(i_hdr, i_len, 4'd0, sdftd_pkg::MG_PDF, 4'd5)) begin
            o_type_code = sdftd_pkg::TC_PDF;
        end else if (sdftd_pkg::hdr_match(i_hdr, i_len, 4'd0, sdftd_pkg::MG_MP3A, 4'd2) ||
                     sdftd_pkg::hdr_match(i_hdr, i_len, 4'd0, sdftd_pkg::MG_MP3B, 4'd2) ||
                     sdftd_pkg::hdr_match(i_hdr, i_len, 4'd0, sdftd_pkg::MG_MP3C, 4'd3)) begin
            o_type_code = sdftd_pkg::TC_MP3;
        end else if (sdftd_pkg::hdr_match(i_hdr, i_len, 4'd0, sdftd_pkg::MG_MP4A, 4'd12) ||
                     sdftd_pkg::hdr_match(i_hdr, i_len, 4'd0, sdftd_pkg::MG_MP4B, 4'd12)) begin
            o_type_code = sdftd_pkg::TC_MP4;
        end else if (sdftd_pkg::hdr_match(i_hdr, i_len, 4'd0, sdftd_pkg::MG_PNG, 4'd8)) begin
            o_type_code = sdftd_pkg::TC_PNG;
        end else if (sdftd_pkg::hdr_match(i_hdr, i_len, 4'd0, sdftd_pkg::MG_GZ, 4'd3)) begin
            o_type_code = sdftd_pkg::TC_GZ;
        end else begin
            o_type_code = sdftd_pkg::TC_NONE;
        end
    end

endmodule

`default_nettype wire

// ===== design/shift_decrypt_file_type_detector.sv =====
`default_nettype none

// Shift-cipher byte decryptor with file type detection. Every input item is one
// encrypted byte; the block returns one item per input with the byte minus key_shift
// (mod 256), a copy of the last-byte flag and, on the last byte only, the file type
// found from the first 12 plain bytes and from "word/", "xl/" or "ppt/" seen within
// the first SEARCH_WINDOW bytes. Throughput is one item per clock: all work happens
// in a single pass from the per-file state registers into the output register. A new
// item enters in the same cycle that the held result is taken; the input stalls only
// while the result side stalls a held result. After the last byte the per-file state
// clears for the next file; key_shift is kept, and the user must write it through
// the configuration port only while the block is idle; the block does not check.
module shift_decrypt_file_type_detector #(
    parameter int unsigned SEARCH_WINDOW = 4096
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_wr_en,
    input  wire [7:0]            i_cfg_wr_data,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wire sdftd_pkg::t_in  i_in_item,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output sdftd_pkg::t_out      o_out_item
);

    localparam int unsigned CNT_W = $clog2(SEARCH_WINDOW + 1);

    logic [7:0]            r_key;
    sdftd_pkg::t_hdr       r_hdr,   n_hdr;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [39:0]           r_recent, n_recent;
    logic [2:0]            r_found, n_found;
    logic                  r_out_valid;
    sdftd_pkg::t_out       r_out,   n_out;

    logic                  accept;
    logic                  in_win;
    logic                  in_hdr;
    logic [7:0]            plain;
    sdftd_pkg::t_hdr_len   hdr_len;
    logic [4:0]            class_code;

    // accept unless a result is held and stalled
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    assign plain  = i_in_item.cipher_byte - r_key;
    assign in_win = r_count < CNT_W'(SEARCH_WINDOW);
    assign in_hdr = r_count < CNT_W'(sdftd_pkg::HDR_LEN);

    // next per-file state
    always_comb begin
        n_hdr = r_hdr;
        for (int i = 0; i < sdftd_pkg::HDR_LEN; i++) begin
            if (in_hdr && r_count[sdftd_pkg::HDR_IDX_W-1:0] == sdftd_pkg::HDR_IDX_W'(i)) begin
                n_hdr[i] = plain;
            end
        end
        n_recent = in_win ? {r_recent[31:0], plain} : r_recent;
        n_count  = in_win ? r_count + CNT_W'(1) : r_count;
        n_found  = r_found;
        if (in_win) begin
            if (n_recent == sdftd_pkg::STR_WORD) n_found[sdftd_pkg::FL_WORD] = 1'b1;
            if (n_recent[23:0] == sdftd_pkg::STR_XL) n_found[sdftd_pkg::FL_XL] = 1'b1;
            if (n_recent[31:0] == sdftd_pkg::STR_PPT) n_found[sdftd_pkg::FL_PPT] = 1'b1;
        end
        hdr_len = (n_count >= CNT_W'(sdftd_pkg::HDR_LEN)) ?
                  sdftd_pkg::HDR_IDX_W'(sdftd_pkg::HDR_LEN) :
                  n_count[sdftd_pkg::HDR_IDX_W-1:0];
    end

    sdftd_classify u_classify (
        .i_hdr       (n_hdr),
        .i_len       (hdr_len),
        .i_found     (n_found),
        .o_type_code (class_code)
    );

    // build the result item
    always_comb begin
        n_out.plain_byte = plain;
        n_out.last_out   = i_in_item.is_last;
        n_out.type_code  = i_in_item.is_last ? class_code : sdftd_pkg::TC_NONE;
    end

    // hold the key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= 8'd0;
        end else if (i_cfg_wr_en) begin
            r_key <= i_cfg_wr_data;
        end
    end

    // advance per-file state, clear after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr    <= '0;
            r_count  <= '0;
            r_recent <= '0;
            r_found  <= '0;
        end else if (accept) begin
            if (i_in_item.is_last) begin
                r_hdr    <= '0;
                r_count  <= '0;
                r_recent <= '0;
                r_found  <= '0;
            end else begin
                r_hdr    <= n_hdr;
                r_count  <= n_count;
                r_recent <= n_recent;
                r_found  <= n_found;
            end
        end
    end

    // output register: load on accept, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

// ===== sim/tb_shift_decrypt_file_type_detector.sv =====
`timescale 1ns / 100ps

module tb_shift_decrypt_file_type_detector;

    // small window so that files can run past it cheaply
    localparam int unsigned SEARCH_WIN  = 32;
    localparam int unsigned QUIET_LIMIT = 4000;
    localparam int unsigned PHASE_ITEMS = 130;

    typedef logic [0:11][7:0] t_hdr12;

    // magic numbers, byte 0 first
    localparam t_hdr12 MAG_3GP  = {8'h00, 8'h00, 8'h00, 8'h14, 8'h66, 8'h74,
                                   8'h79, 8'h70, 8'h33, 8'h67, 8'h70, 8'h34};
    localparam t_hdr12 MAG_AVI  = {8'h52, 8'h49, 8'h46, 8'h46, 64'h0};
    localparam t_hdr12 MAG_BMP  = {8'h42, 8'h4D, 80'h0};
    localparam t_hdr12 MAG_JPG  = {8'hFF, 8'hD8, 8'hFF, 8'hE0, 64'h0};
    localparam t_hdr12 MAG_EXE  = {8'h4D, 8'h5A, 80'h0};
    localparam t_hdr12 MAG_OLE  = {8'hD0, 8'hCF, 8'h11, 8'hE0, 8'hA1, 8'hB1,
                                   8'h1A, 8'hE1, 32'h0};
    localparam t_hdr12 MAG_ZIP  = {8'h50, 8'h4B, 8'h03, 8'h04, 64'h0};
    localparam t_hdr12 MAG_PDF  = {8'h25, 8'h50, 8'h44, 8'h46, 8'h2D, 56'h0};
    localparam t_hdr12 MAG_MP3A = {8'hFF, 8'hFB, 80'h0};
    localparam t_hdr12 MAG_MP3B = {8'hFF, 8'hF3, 80'h0};
    localparam t_hdr12 MAG_MP3C = {8'h49, 8'h44, 8'h33, 72'h0};
    localparam t_hdr12 MAG_MP4A = {8'h00, 8'h00, 8'h00, 8'h18, 8'h66, 8'h74,
                                   8'h79, 8'h70, 8'h6D, 8'h70, 8'h34, 8'h32};
    localparam t_hdr12 MAG_MP4B = {8'h00, 8'h00, 8'h00, 8'h14, 8'h66, 8'h74,
                                   8'h79, 8'h70, 8'h69, 8'h73, 8'h6F, 8'h6D};
    localparam t_hdr12 MAG_PNG  = {8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A,
                                   8'h1A, 8'h0A, 32'h0};
    localparam t_hdr12 MAG_GZ   = {8'h1F, 8'h8B, 8'h08, 72'h0};

    // OLE subtype bytes at their place in the header
    localparam t_hdr12 TAIL_XLS = {64'h0, 8'h09, 8'h08, 16'h0};
    localparam t_hdr12 TAIL_DOC = {64'h0, 8'h00, 8'h46, 8'h49, 8'h4C};
    localparam t_hdr12 TAIL_PPT = {64'h0, 8'h00, 8'h6E, 8'h1E, 8'hF0};

    // archive paths, last byte lowest
    localparam logic [39:0] W_WORD = 40'h776F72642F;
    localparam logic [23:0] W_XL   = 24'h786C2F;
    localparam logic [31:0] W_PPT  = 32'h7070742F;

    typedef enum int {
        SH_3GP, SH_AVI, SH_BMP, SH_JPG, SH_EXE, SH_OLE_XLS, SH_OLE_DOC, SH_OLE_PPT,
        SH_OLE_BARE, SH_ZIP_WORD, SH_ZIP_XL, SH_ZIP_PPT, SH_ZIP_BARE, SH_PDF,
        SH_MP3A, SH_MP3B, SH_MP3C, SH_MP4A, SH_MP4B, SH_PNG, SH_GZ, SH_NOISE
    } t_file_shape;

    typedef enum int {PATH_NONE, PATH_WORD, PATH_XL, PATH_PPT} t_path;

    // Expected plain bytes and file types, in order of acceptance
    class decrypt_scoreboard;
        logic [7:0]  key;
        t_hdr12      head;
        int unsigned seen_bytes;
        logic [39:0] window_tail;
        logic [2:0]  paths_seen;
        sdftd_pkg::t_out results_due[$];
        int unsigned errors;
        int unsigned checked;
        int unsigned files;
        logic [16:0] codes_hit;

        function new();
            key       = '0;
            errors    = 0;
            checked   = 0;
            files     = 0;
            codes_hit = '0;
            clear_file();
        endfunction

        function void clear_file();
            head        = '0;
            seen_bytes  = 0;
            window_tail = '0;
            paths_seen  = '0;
        endfunction

        // header holds want at pos..pos+n-1 and the file reaches that far
        function bit head_has(int unsigned len, int unsigned pos, t_hdr12 want,
                              int unsigned n);
            if (len < pos + n) return 1'b0;
            for (int unsigned i = pos; i < pos + n; i++) begin
                if (head[i] != want[i]) return 1'b0;
            end
            return 1'b1;
        endfunction

        // first table entry that fits, in table order
        function logic [4:0] detect_type(int unsigned len);
            if (head_has(len, 0, MAG_3GP, 12)) return sdftd_pkg::TC_3GP;
            if (head_has(len, 0, MAG_AVI, 4))  return sdftd_pkg::TC_AVI;
            if (head_has(len, 0, MAG_BMP, 2))  return sdftd_pkg::TC_BMP;
            if (head_has(len, 0, MAG_JPG, 4))  return sdftd_pkg::TC_JPG;
            if (head_has(len, 0, MAG_EXE, 2))  return sdftd_pkg::TC_EXE;
            if (head_has(len, 0, MAG_OLE, 8)) begin
                if (head_has(len, 8, TAIL_XLS, 2)) return sdftd_pkg::TC_XLS;
                if (head_has(len, 8, TAIL_DOC, 4)) return sdftd_pkg::TC_DOC;
                if (head_has(len, 8, TAIL_PPT, 4)) return sdftd_pkg::TC_PPT;
            end
            if (head_has(len, 0, MAG_ZIP, 4)) begin
                if (paths_seen[sdftd_pkg::FL_WORD]) return sdftd_pkg::TC_DOCX;
                if (paths_seen[sdftd_pkg::FL_XL])   return sdftd_pkg::TC_XLSX;
                if (paths_seen[sdftd_pkg::FL_PPT])  return sdftd_pkg::TC_PPTX;
            end
            if (head_has(len, 0, MAG_PDF, 5))   return sdftd_pkg::TC_PDF;
            if (head_has(len, 0, MAG_MP3A, 2))  return sdftd_pkg::TC_MP3;
            if (head_has(len, 0, MAG_MP3B, 2))  return sdftd_pkg::TC_MP3;
            if (head_has(len, 0, MAG_MP3C, 3))  return sdftd_pkg::TC_MP3;
            if (head_has(len, 0, MAG_MP4A, 12)) return sdftd_pkg::TC_MP4;
            if (head_has(len, 0, MAG_MP4B, 12)) return sdftd_pkg::TC_MP4;
            if (head_has(len, 0, MAG_PNG, 8))   return sdftd_pkg::TC_PNG;
            if (head_has(len, 0, MAG_GZ, 3))    return sdftd_pkg::TC_GZ;
            return sdftd_pkg::TC_NONE;
        endfunction

        function void note_cipher_byte(sdftd_pkg::t_in item);
            sdftd_pkg::t_out due;
            logic [7:0]      plain;
            plain = item.cipher_byte - key;
            if (seen_bytes < 12) head[seen_bytes] = plain;
            // track paths only inside the search window
            if (seen_bytes < SEARCH_WIN) begin
                window_tail = {window_tail[31:0], plain};
                if (window_tail == W_WORD)      paths_seen[sdftd_pkg::FL_WORD] = 1'b1;
                if (window_tail[23:0] == W_XL)  paths_seen[sdftd_pkg::FL_XL]   = 1'b1;
                if (window_tail[31:0] == W_PPT) paths_seen[sdftd_pkg::FL_PPT]  = 1'b1;
                seen_bytes++;
            end
            due.plain_byte = plain;
            due.last_out   = item.is_last;
            due.type_code  = sdftd_pkg::TC_NONE;
            if (item.is_last) begin
                due.type_code = detect_type(seen_bytes);
                codes_hit[due.type_code] = 1'b1;
                files++;
                clear_file();
            end
            results_due.push_back(due);
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        task check_plain_item(sdftd_pkg::t_out got);
            sdftd_pkg::t_out want;
            if (results_due.size() == 0) begin
                report($sformatf("result %h/%b/%0d with nothing due",
                                 got.plain_byte, got.last_out, got.type_code));
                return;
            end
            want = results_due.pop_front();
            checked++;
            if (got.plain_byte !== want.plain_byte)
                report($sformatf("item %0d plain_byte %h, want %h",
                                 checked, got.plain_byte, want.plain_byte));
            if (got.last_out !== want.last_out)
                report($sformatf("item %0d last_out %b, want %b",
                                 checked, got.last_out, want.last_out));
            if (got.type_code !== want.type_code)
                report($sformatf("item %0d type_code %0d, want %0d",
                                 checked, got.type_code, want.type_code));
        endtask
    endclass

    logic            clk = 1'b0;
    logic            rst_n;
    logic            cfg_wr_en;
    logic [7:0]      cfg_wr_data;
    logic            in_valid;
    logic            in_stall;
    sdftd_pkg::t_in  in_item;
    logic            out_valid;
    logic            out_stall;
    sdftd_pkg::t_out out_item;

    int unsigned send_idle_pct;
    int unsigned stall_pct;
    int unsigned items_sent;
    int unsigned quiet = 0;
    logic [7:0]  plain_file[$];
    decrypt_scoreboard sb;

    shift_decrypt_file_type_detector #(
        .SEARCH_WINDOW(SEARCH_WIN)
    ) u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_in_item    (in_item),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_out_item   (out_item)
    );

    always #5 clk = ~clk;

    // stall the result side at random
    always @(negedge clk) begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // check every accepted result
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.check_plain_item(out_item);
    end

    // end the run if nothing moves for too long
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
        else quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("FAIL shift_decrypt_file_type_detector");
            $finish;
        end
    end

    // offer one item, with random gaps before it, and hold it until taken
    task automatic drive_item(input sdftd_pkg::t_in item);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_cipher_byte(item);
        items_sent++;
        @(negedge clk);
    endtask

    // encrypt the plain file with the current key and send it
    task automatic send_file();
        sdftd_pkg::t_in item;
        foreach (plain_file[i]) begin
            item.cipher_byte = plain_file[i] + sb.key;
            item.is_last     = (i == plain_file.size() - 1);
            drive_item(item);
        end
    endtask

    task automatic load_prefix(input t_hdr12 bytes, input int unsigned n);
        plain_file.delete();
        for (int unsigned i = 0; i < n; i++) plain_file.push_back(bytes[i]);
    endtask

    // hold off until every result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.results_due.size() != 0) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_key(input logic [7:0] k);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= k;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        sb.key = k;
    endtask

    // a file of some shape: magic, random body, maybe a path, maybe damaged
    task automatic build_file();
        t_file_shape shape;
        t_path       path;
        t_hdr12      pre;
        int unsigned n_pre;
        int unsigned flen;
        int unsigned roll;
        int unsigned spos;
        int unsigned slen;
        int unsigned idx;
        int unsigned n_str;
        logic [39:0] str;
        shape = t_file_shape'($urandom_range(0, SH_NOISE));
        path  = PATH_NONE;
        pre   = '0;
        n_pre = 0;
        case (shape)
            SH_3GP: begin pre = MAG_3GP; n_pre = 12; end
            SH_AVI: begin pre = MAG_AVI; n_pre = 4; end
            SH_BMP: begin pre = MAG_BMP; n_pre = 2; end
            SH_JPG: begin pre = MAG_JPG; n_pre = 4; end
            SH_EXE: begin pre = MAG_EXE; n_pre = 2; end
            SH_OLE_XLS: begin pre = MAG_OLE | TAIL_XLS; n_pre = 10; end
            SH_OLE_DOC: begin pre = MAG_OLE | TAIL_DOC; n_pre = 12; end
            SH_OLE_PPT: begin pre = MAG_OLE | TAIL_PPT; n_pre = 12; end
            SH_OLE_BARE: begin pre = MAG_OLE; n_pre = 8; end
            SH_ZIP_WORD: begin pre = MAG_ZIP; n_pre = 4; path = PATH_WORD; end
            SH_ZIP_XL: begin pre = MAG_ZIP; n_pre = 4; path = PATH_XL; end
            SH_ZIP_PPT: begin pre = MAG_ZIP; n_pre = 4; path = PATH_PPT; end
            SH_ZIP_BARE: begin pre = MAG_ZIP; n_pre = 4; end
            SH_PDF: begin pre = MAG_PDF; n_pre = 5; end
            SH_MP3A: begin pre = MAG_MP3A; n_pre = 2; end
            SH_MP3B: begin pre = MAG_MP3B; n_pre = 2; end
            SH_MP3C: begin pre = MAG_MP3C; n_pre = 3; end
            SH_MP4A: begin pre = MAG_MP4A; n_pre = 12; end
            SH_MP4B: begin pre = MAG_MP4B; n_pre = 12; end
            SH_PNG: begin pre = MAG_PNG; n_pre = 8; end
            SH_GZ: begin pre = MAG_GZ; n_pre = 3; end
            default: begin end
        endcase
        if (path == PATH_NONE && $urandom_range(0, 6) == 0)
            path = t_path'($urandom_range(PATH_WORD, PATH_PPT));

        // mostly short files, some cut inside the magic, some past the window
        roll = $urandom_range(0, 99);
        if (roll < 10 && n_pre > 1) flen = $urandom_range(1, n_pre - 1);
        else if (roll < 18) flen = $urandom_range(SEARCH_WIN - 8, SEARCH_WIN + 12);
        else flen = n_pre + $urandom_range(0, 16);
        if (flen == 0) flen = 1;
        load_prefix(pre, (n_pre < flen) ? n_pre : flen);
        while (plain_file.size() < flen) plain_file.push_back(8'($urandom_range(0, 255)));

        // flip one bit of the magic now and then
        if (n_pre != 0 && $urandom_range(0, 9) == 0) begin
            idx = $urandom_range(0, ((plain_file.size() < n_pre) ?
                                     plain_file.size() : n_pre) - 1);
            plain_file[idx] ^= 8'h01 << $urandom_range(0, 7);
        end

        // plant one or two paths, some of them at the window edge
        n_str = (path == PATH_NONE) ? 0 : 1 + ($urandom_range(0, 3) == 0);
        for (int unsigned k = 0; k < n_str; k++) begin
            if (k > 0) path = t_path'($urandom_range(PATH_WORD, PATH_PPT));
            case (path)
                PATH_WORD: begin str = W_WORD; slen = 5; end
                PATH_XL:   begin str = {16'h0, W_XL}; slen = 3; end
                default:   begin str = {8'h0, W_PPT}; slen = 4; end
            endcase
            if ($urandom_range(0, 2) == 0) spos = SEARCH_WIN - slen - 1 + $urandom_range(0, 2);
            else spos = n_pre + $urandom_range(0, 8);
            while (plain_file.size() < spos + slen)
                plain_file.push_back(8'($urandom_range(0, 255)));
            for (int unsigned j = 0; j < slen; j++)
                plain_file[spos + j] = str[8 * (slen - 1 - j) +: 8];
        end
    endtask

    initial begin
        logic [7:0]  keys [6];
        int unsigned target;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        in_valid      = 1'b0;
        in_item       = '0;
        out_stall     = 1'b0;
        send_idle_pct = 17;
        stall_pct     = 61;
        items_sent    = 0;
        sb            = new();

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed files under the reset key
        plain_file = '{8'hFF};
        send_file();
        plain_file = '{8'h00};
        send_file();
        load_prefix(MAG_BMP, 2);
        send_file();
        load_prefix(MAG_GZ, 3);
        send_file();
        load_prefix(MAG_OLE | TAIL_XLS, 10);
        send_file();
        // OLE file that ends before the last of its subtype bytes
        load_prefix(MAG_OLE | TAIL_DOC, 11);
        send_file();

        // random files over several keys and idling patterns
        keys[0] = 8'hFF;
        keys[1] = 8'h00;
        keys[2] = 8'h01;
        keys[3] = 8'($urandom_range(0, 255));
        keys[4] = 8'h80;
        keys[5] = 8'($urandom_range(0, 255));
        for (int p = 0; p < 6; p++) begin
            case (p / 2)
                0: begin send_idle_pct = 17; stall_pct = 61; end
                1: begin send_idle_pct = 61; stall_pct = 17; end
                default: begin send_idle_pct = 0; stall_pct = 0; end
            endcase
            write_key(keys[p]);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                build_file();
                send_file();
            end
        end

        drain_results();
        repeat (3) @(posedge clk);
        $display("Covered %0d bytes in %0d files under 6 key settings, %0d results checked.",
                 items_sent, sb.files, sb.checked);
        $display("Type codes reported (bit per code): %b", sb.codes_hit);
        if (sb.errors == 0 && sb.results_due.size() == 0) begin
            $display("PASS shift_decrypt_file_type_detector");
        end else begin
            $display("FAIL shift_decrypt_file_type_detector");
        end
        $finish;
    end

endmodule
